// ----- rtl/i2d_pkg.sv -----
`timescale 1ns / 1ps

package i2d_pkg;

    localparam int VALUE_W     = 64;
    localparam int BIT_CNT_W   = 6;
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIGIT_CNT_W = 5;
    localparam int CHAR_W      = 8;
    localparam int S_TDATA_W   = 64;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    localparam logic [BIT_CNT_W-1:0]   LAST_BIT   = 6'd63;
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ALL = 5'd20;
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_ONE  = 5'd1;

endpackage

// ----- rtl/int64_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts a 64-bit value into decimal ASCII text.
// Input channel s_axis: one request carries the value in tdata[63:0] and the
// signed flag in tuser; with the flag set the value is two's complement.
// Output channel m_axis: one character per transfer in tdata[7:0], most
// significant first, a leading '-' for a negative signed value, and tlast
// on the final character. Zero gives the single character '0'.
// An accepted request runs through the shift-and-add-3 unit (one value bit
// per cycle), then drops leading zero digits and settles on the top digit,
// then sends one character per cycle while the receiver is ready.
// s_axis_tready is high only while the block is idle, which includes the time
// the final character still waits in the output register, so a new request
// can be taken before the last one is fully sent. When the receiver stalls,
// the current character holds in the output register and character output
// pauses. A synchronous active-low reset returns the block to idle and drops
// m_axis_tvalid; nothing survives between requests.
module int64_to_decimal_ascii (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [i2d_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // value_bits
    input  logic                            s_axis_tuser,  // signed_mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [i2d_pkg::CHAR_W-1:0]      m_axis_tdata,  // character
    output logic                            m_axis_tlast
);
    import i2d_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic                   minus_reg, minus_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic [BCD_W-1:0]   step_bcd;
    logic [VALUE_W-1:0] step_mag;
    logic [VALUE_W-1:0] in_value;
    logic               in_minus;
    logic               out_free;
    logic [3:0]         top_digit;

    i2d_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .mag_in  (mag_reg),
        .bcd_out (step_bcd),
        .mag_out (step_mag)
    );

    assign in_value  = s_axis_tdata[VALUE_W-1:0];
    assign in_minus  = s_axis_tuser & in_value[VALUE_W-1];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        minus_next     = minus_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    minus_next   = in_minus;
                    mag_next     = in_minus ? (~in_value + 1'b1) : in_value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = step_bcd;
                mag_next     = step_mag;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    dig_cnt_next = DIGITS_ALL;
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits, but always keep the last one.
                if (top_digit == 4'd0 && dig_cnt_reg != DIGIT_ONE) begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (minus_reg) begin
                        // At least one digit follows the sign.
                        out_char_next = ASCII_MINUS;
                        out_last_next = 1'b0;
                        minus_next    = 1'b0;
                    end else begin
                        out_char_next = ASCII_ZERO + {4'd0, top_digit};
                        out_last_next = (dig_cnt_reg == DIGIT_ONE);
                        bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                        dig_cnt_next  = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == DIGIT_ONE) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        minus_reg    <= minus_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- rtl/i2d_dabble.sv -----
`timescale 1ns / 1ps

module i2d_dabble (
    input  logic [i2d_pkg::BCD_W-1:0]   bcd_in,
    input  logic [i2d_pkg::VALUE_W-1:0] mag_in,
    output logic [i2d_pkg::BCD_W-1:0]   bcd_out,
    output logic [i2d_pkg::VALUE_W-1:0] mag_out
);
    import i2d_pkg::*;

    logic [BCD_W-1:0] adjusted;

    // Each BCD digit of five or more gets three added before the shift,
    // so that the doubling carries correctly into the next digit.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[4*d +: 4] >= 4'd5) begin
                adjusted[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
            end else begin
                adjusted[4*d +: 4] = bcd_in[4*d +: 4];
            end
        end
    end

    assign bcd_out = {adjusted[BCD_W-2:0], mag_in[VALUE_W-1]};
    assign mag_out = {mag_in[VALUE_W-2:0], 1'b0};

endmodule
